FILE: rtl/core/assert_macros.svh
// Assertion macros for the ALU RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CALU_ASSERT_NOW(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CALU_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/calu_pkg.sv
// Operation codes and beat types for the ALU.
package calu_pkg;

    localparam logic [4:0] KIND_ADD    = 5'd0;
    localparam logic [4:0] KIND_ADC    = 5'd1;
    localparam logic [4:0] KIND_SUB    = 5'd2;
    localparam logic [4:0] KIND_SBC    = 5'd3;
    localparam logic [4:0] KIND_AND    = 5'd4;
    localparam logic [4:0] KIND_XOR    = 5'd5;
    localparam logic [4:0] KIND_OR     = 5'd6;
    localparam logic [4:0] KIND_CP     = 5'd7;
    localparam logic [4:0] KIND_INC    = 5'd8;
    localparam logic [4:0] KIND_DEC    = 5'd9;
    localparam logic [4:0] KIND_CCF    = 5'd10;
    localparam logic [4:0] KIND_SCF    = 5'd11;
    localparam logic [4:0] KIND_RRA    = 5'd12;
    localparam logic [4:0] KIND_RLA    = 5'd13;
    localparam logic [4:0] KIND_RLCA   = 5'd14;
    localparam logic [4:0] KIND_RRCA   = 5'd15;
    localparam logic [4:0] KIND_CPL    = 5'd16;
    localparam logic [4:0] KIND_BIT    = 5'd17;
    localparam logic [4:0] KIND_RES    = 5'd18;
    localparam logic [4:0] KIND_SET    = 5'd19;
    localparam logic [4:0] KIND_SRL    = 5'd20;
    localparam logic [4:0] KIND_SLL    = 5'd21;
    localparam logic [4:0] KIND_RR     = 5'd22;
    localparam logic [4:0] KIND_RL     = 5'd23;
    localparam logic [4:0] KIND_RRC    = 5'd24;
    localparam logic [4:0] KIND_RLC    = 5'd25;
    localparam logic [4:0] KIND_SRA    = 5'd26;
    localparam logic [4:0] KIND_SLA    = 5'd27;
    localparam logic [4:0] KIND_SWAP   = 5'd28;
    localparam logic [4:0] KIND_ADD_HL = 5'd29;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [2:0]  bit_index;
        logic [15:0] pair_value;
        logic [15:0] wide_addend;
        flags_t      flags;
    } op_beat_t;

    typedef struct packed {
        logic [15:0] result;
        logic        writes_result;
        flags_t      flags;
    } res_beat_t;

endpackage

FILE: rtl/core/cpu_alu_with_flags.sv
// Top level of the 8/16-bit ALU with Z, N, H and C flags.
//
// One beat in, one beat out. An accepted operation is captured in an input
// register, evaluated by the single-level datapath in calu_core and captured
// in the result register, which presents it until out_ready takes it. Both stages
// advance together whenever the result register is empty or being taken, so
// one operation is accepted every cycle while the output side keeps up; a
// stall on out_ready backs up through both stages.
// Unused operation codes give a zero result, no write and unchanged flags.
module cpu_alu_with_flags
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  kind,
    input  logic [7:0]  acc,
    input  logic [7:0]  operand,
    input  logic [2:0]  bit_index,
    input  logic [15:0] pair_value,
    input  logic [15:0] wide_addend,
    input  logic        zero_in,
    input  logic        sub_in,
    input  logic        half_in,
    input  logic        carry_flag,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result,
    output logic        writes_result,
    output logic        zero_out,
    output logic        sub_out,
    output logic        half_out,
    output logic        carry_out
);

`include "assert_macros.svh"

    calu_pkg::op_beat_t  op_reg;
    calu_pkg::op_beat_t  op_next;
    calu_pkg::res_beat_t res_reg;
    calu_pkg::res_beat_t res_next;
    logic                op_valid_reg;
    logic                res_valid_reg;
    logic                advance;

    assign advance  = !res_valid_reg || out_ready;
    assign in_ready = advance || !op_valid_reg;

    always_comb
    begin
        op_next.kind        = kind;
        op_next.acc         = acc;
        op_next.operand     = operand;
        op_next.bit_index   = bit_index;
        op_next.pair_value  = pair_value;
        op_next.wide_addend = wide_addend;
        op_next.flags       = '{z: zero_in, n: sub_in, h: half_in, c: carry_flag};
    end

    calu_core u_core
    (
        .op  (op_reg),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                op_valid_reg <= in_valid;
            if (advance)
                res_valid_reg <= op_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            op_reg <= op_next;
        if (advance && op_valid_reg)
            res_reg <= res_next;
    end

    assign out_valid     = res_valid_reg;
    assign result        = res_reg.result;
    assign writes_result = res_reg.writes_result;
    assign zero_out      = res_reg.flags.z;
    assign sub_out       = res_reg.flags.n;
    assign half_out      = res_reg.flags.h;
    assign carry_out     = res_reg.flags.c;

    // a waiting result is never dropped
    `CALU_ASSERT_NEXT(a_res_held, clk, rst_n, res_valid_reg && !out_ready, res_valid_reg)
    // a full input stage behind a stalled output blocks new beats
    `CALU_ASSERT_NOW(a_stall_blocks, clk, rst_n, op_valid_reg && res_valid_reg && !out_ready, !in_ready)
    // an operation moving forward lands in the result register
    `CALU_ASSERT_NEXT(a_op_moves, clk, rst_n, op_valid_reg && advance, res_valid_reg)

endmodule

FILE: rtl/core/calu_core.sv
// Combinational datapath: value and flags for one operation.
module calu_core
(
    input  calu_pkg::op_beat_t  op,
    output calu_pkg::res_beat_t res
);

    logic        cin_add;
    logic        cin_sub;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [7:0]  diff8;
    logic        h_sub;
    logic        c_sub;
    logic [7:0]  mask;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [16:0] sum17;
    logic [12:0] hsum13;
    logic [7:0]  logic8;
    logic [7:0]  sh8;
    logic        sh_c;
    logic        ci;
    logic [7:0]  a;
    logic [7:0]  b;

    assign a  = op.acc;
    assign b  = op.operand;
    assign ci = op.flags.c;

    assign cin_add = (op.kind == calu_pkg::KIND_ADC) & ci;
    assign cin_sub = (op.kind == calu_pkg::KIND_SBC) & ci;
    assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
    assign hsum5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
    assign diff8   = a - b - {7'd0, cin_sub};
    assign h_sub   = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, cin_sub});
    assign c_sub   = {1'b0, a} < ({1'b0, b} + {8'd0, cin_sub});
    assign mask    = 8'd1 << op.bit_index;
    assign inc8    = b + 8'd1;
    assign dec8    = b - 8'd1;
    assign sum17   = {1'b0, op.pair_value} + {1'b0, op.wide_addend};
    assign hsum13  = {1'b0, op.pair_value[11:0]} + {1'b0, op.wide_addend[11:0]};

    always_comb
    begin
        case (op.kind)
            calu_pkg::KIND_AND: logic8 = a & b;
            calu_pkg::KIND_XOR: logic8 = a ^ b;
            default:            logic8 = a | b;
        endcase
    end

    always_comb
    begin
        case (op.kind)
            calu_pkg::KIND_SRL:
            begin
                sh8  = {1'b0, b[7:1]};
                sh_c = b[0];
            end
            calu_pkg::KIND_RR:
            begin
                sh8  = {ci, b[7:1]};
                sh_c = b[0];
            end
            calu_pkg::KIND_RL:
            begin
                sh8  = {b[6:0], ci};
                sh_c = b[7];
            end
            calu_pkg::KIND_RRC:
            begin
                sh8  = {b[0], b[7:1]};
                sh_c = b[0];
            end
            calu_pkg::KIND_RLC:
            begin
                sh8  = {b[6:0], b[7]};
                sh_c = b[7];
            end
            calu_pkg::KIND_SRA:
            begin
                sh8  = {b[7], b[7:1]};
                sh_c = b[0];
            end
            calu_pkg::KIND_SWAP:
            begin
                sh8  = {b[3:0], b[7:4]};
                sh_c = 1'b0;
            end
            default:
            begin
                sh8  = {b[6:0], 1'b0};
                sh_c = b[7];
            end
        endcase
    end

    always_comb
    begin
        res.result        = 16'd0;
        res.writes_result = 1'b1;
        res.flags         = op.flags;
        case (op.kind)
            calu_pkg::KIND_ADD, calu_pkg::KIND_ADC:
            begin
                res.result = {8'd0, sum9[7:0]};
                res.flags  = '{z: sum9[7:0] == 8'd0, n: 1'b0, h: hsum5[4], c: sum9[8]};
            end
            calu_pkg::KIND_SUB, calu_pkg::KIND_SBC, calu_pkg::KIND_CP:
            begin
                res.result        = {8'd0, diff8};
                res.writes_result = (op.kind != calu_pkg::KIND_CP);
                res.flags         = '{z: diff8 == 8'd0, n: 1'b1, h: h_sub, c: c_sub};
            end
            calu_pkg::KIND_AND, calu_pkg::KIND_XOR, calu_pkg::KIND_OR:
            begin
                res.result = {8'd0, logic8};
                res.flags  = '{z: logic8 == 8'd0, n: 1'b0,
                               h: op.kind == calu_pkg::KIND_AND, c: 1'b0};
            end
            calu_pkg::KIND_INC:
            begin
                res.result = {8'd0, inc8};
                res.flags  = '{z: inc8 == 8'd0, n: 1'b0, h: b[3:0] == 4'hF, c: ci};
            end
            calu_pkg::KIND_DEC:
            begin
                res.result = {8'd0, dec8};
                res.flags  = '{z: dec8 == 8'd0, n: 1'b1, h: b[3:0] == 4'h0, c: ci};
            end
            calu_pkg::KIND_CCF, calu_pkg::KIND_SCF:
            begin
                res.result        = {8'd0, a};
                res.writes_result = 1'b0;
                res.flags         = '{z: op.flags.z, n: 1'b0, h: 1'b0,
                                      c: (op.kind == calu_pkg::KIND_SCF) | ~ci};
            end
            calu_pkg::KIND_RRA:
            begin
                res.result = {8'd0, ci, a[7:1]};
                res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            calu_pkg::KIND_RLA:
            begin
                res.result = {8'd0, a[6:0], ci};
                res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            calu_pkg::KIND_RLCA:
            begin
                res.result = {8'd0, a[6:0], a[7]};
                res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            calu_pkg::KIND_RRCA:
            begin
                res.result = {8'd0, a[0], a[7:1]};
                res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            calu_pkg::KIND_CPL:
            begin
                res.result = {8'd0, ~a};
                res.flags  = '{z: op.flags.z, n: 1'b1, h: 1'b1, c: ci};
            end
            calu_pkg::KIND_BIT:
            begin
                res.result        = {8'd0, b};
                res.writes_result = 1'b0;
                res.flags         = '{z: (b & mask) == 8'd0, n: 1'b0, h: 1'b1, c: ci};
            end
            calu_pkg::KIND_RES:
                res.result = {8'd0, b & ~mask};
            calu_pkg::KIND_SET:
                res.result = {8'd0, b | mask};
            calu_pkg::KIND_SRL, calu_pkg::KIND_SLL, calu_pkg::KIND_RR,
            calu_pkg::KIND_RL, calu_pkg::KIND_RRC, calu_pkg::KIND_RLC,
            calu_pkg::KIND_SRA, calu_pkg::KIND_SLA, calu_pkg::KIND_SWAP:
            begin
                res.result = {8'd0, sh8};
                res.flags  = '{z: sh8 == 8'd0, n: 1'b0, h: 1'b0, c: sh_c};
            end
            calu_pkg::KIND_ADD_HL:
            begin
                res.result = sum17[15:0];
                res.flags  = '{z: op.flags.z, n: 1'b0, h: hsum13[12], c: sum17[16]};
            end
            default:
                res.writes_result = 1'b0;
        endcase
    end

endmodule

FILE: dv/tb.sv
// Self-checking bench for cpu_alu_with_flags: result and flag prediction, random stalls.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // highest code, with no operation behind it
    localparam logic [4:0] KIND_SPARE_HI = 5'd31;

    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PRINT_LIMIT  = 40;

    typedef struct {
        calu_pkg::op_beat_t  op;
        calu_pkg::res_beat_t want;
    } due_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [4:0]  kind;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [2:0]  bit_index;
    logic [15:0] pair_value;
    logic [15:0] wide_addend;
    logic        zero_in;
    logic        sub_in;
    logic        half_in;
    logic        carry_flag;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] result;
    logic        writes_result;
    logic        zero_out;
    logic        sub_out;
    logic        half_out;
    logic        carry_out;

    due_t        due_results[$];
    int unsigned err_count   = 0;
    int unsigned hold_cycles = 0;
    bit          steady      = 1'b0;

    cpu_alu_with_flags u_dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic calu_pkg::res_beat_t compute_alu(input calu_pkg::op_beat_t op);
        calu_pkg::res_beat_t r;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  val;
        logic [7:0]  mask;
        logic [8:0]  sum9;
        logic [4:0]  nib5;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic        cin;
        logic        cy;
        a = op.acc;
        b = op.operand;
        mask = 8'h01 << op.bit_index;
        r.result = 16'h0000;
        r.writes_result = 1'b1;
        r.flags = op.flags;
        case (op.kind)
            calu_pkg::KIND_ADD, calu_pkg::KIND_ADC:
            begin
                cin = (op.kind == calu_pkg::KIND_ADC) ? op.flags.c : 1'b0;
                sum9 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
                nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
                r.result = {8'h00, sum9[7:0]};
                r.flags.z = (sum9[7:0] == 8'h00);
                r.flags.n = 1'b0;
                r.flags.h = nib5[4];
                r.flags.c = sum9[8];
            end
            calu_pkg::KIND_SUB, calu_pkg::KIND_SBC, calu_pkg::KIND_CP:
            begin
                cin = (op.kind == calu_pkg::KIND_SBC) ? op.flags.c : 1'b0;
                val = a - b - {7'h00, cin};
                r.result = {8'h00, val};
                r.writes_result = (op.kind != calu_pkg::KIND_CP);
                r.flags.z = (val == 8'h00);
                r.flags.n = 1'b1;
                r.flags.h = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, cin});
                r.flags.c = {1'b0, a} < ({1'b0, b} + {8'h00, cin});
            end
            calu_pkg::KIND_AND, calu_pkg::KIND_XOR, calu_pkg::KIND_OR:
            begin
                if (op.kind == calu_pkg::KIND_AND)
                    val = a & b;
                else if (op.kind == calu_pkg::KIND_XOR)
                    val = a ^ b;
                else
                    val = a | b;
                r.result = {8'h00, val};
                r.flags.z = (val == 8'h00);
                r.flags.n = 1'b0;
                r.flags.h = (op.kind == calu_pkg::KIND_AND);
                r.flags.c = 1'b0;
            end
            calu_pkg::KIND_INC:
            begin
                val = b + 8'h01;
                r.result = {8'h00, val};
                r.flags.z = (val == 8'h00);
                r.flags.n = 1'b0;
                r.flags.h = (b[3:0] == 4'hF);
            end
            calu_pkg::KIND_DEC:
            begin
                val = b - 8'h01;
                r.result = {8'h00, val};
                r.flags.z = (val == 8'h00);
                r.flags.n = 1'b1;
                r.flags.h = (b[3:0] == 4'h0);
            end
            calu_pkg::KIND_CCF, calu_pkg::KIND_SCF:
            begin
                r.result = {8'h00, a};
                r.writes_result = 1'b0;
                r.flags.n = 1'b0;
                r.flags.h = 1'b0;
                r.flags.c = (op.kind == calu_pkg::KIND_SCF) ? 1'b1 : ~op.flags.c;
            end
            calu_pkg::KIND_RRA, calu_pkg::KIND_RLA, calu_pkg::KIND_RLCA,
            calu_pkg::KIND_RRCA:
            begin
                case (op.kind)
                    calu_pkg::KIND_RRA:
                    begin
                        val = {op.flags.c, a[7:1]};
                        cy  = a[0];
                    end
                    calu_pkg::KIND_RLA:
                    begin
                        val = {a[6:0], op.flags.c};
                        cy  = a[7];
                    end
                    calu_pkg::KIND_RLCA:
                    begin
                        val = {a[6:0], a[7]};
                        cy  = a[7];
                    end
                    default:
                    begin
                        val = {a[0], a[7:1]};
                        cy  = a[0];
                    end
                endcase
                r.result = {8'h00, val};
                r.flags.z = 1'b0;
                r.flags.n = 1'b0;
                r.flags.h = 1'b0;
                r.flags.c = cy;
            end
            calu_pkg::KIND_CPL:
            begin
                r.result = {8'h00, ~a};
                r.flags.n = 1'b1;
                r.flags.h = 1'b1;
            end
            calu_pkg::KIND_BIT:
            begin
                r.result = {8'h00, b};
                r.writes_result = 1'b0;
                r.flags.z = ((b & mask) == 8'h00);
                r.flags.n = 1'b0;
                r.flags.h = 1'b1;
            end
            calu_pkg::KIND_RES: r.result = {8'h00, b & ~mask};
            calu_pkg::KIND_SET: r.result = {8'h00, b | mask};
            calu_pkg::KIND_SRL, calu_pkg::KIND_SLL, calu_pkg::KIND_RR, calu_pkg::KIND_RL,
            calu_pkg::KIND_RRC, calu_pkg::KIND_RLC, calu_pkg::KIND_SRA, calu_pkg::KIND_SLA,
            calu_pkg::KIND_SWAP:
            begin
                case (op.kind)
                    calu_pkg::KIND_SRL:
                    begin
                        val = {1'b0, b[7:1]};
                        cy  = b[0];
                    end
                    calu_pkg::KIND_RR:
                    begin
                        val = {op.flags.c, b[7:1]};
                        cy  = b[0];
                    end
                    calu_pkg::KIND_RL:
                    begin
                        val = {b[6:0], op.flags.c};
                        cy  = b[7];
                    end
                    calu_pkg::KIND_RRC:
                    begin
                        val = {b[0], b[7:1]};
                        cy  = b[0];
                    end
                    calu_pkg::KIND_RLC:
                    begin
                        val = {b[6:0], b[7]};
                        cy  = b[7];
                    end
                    calu_pkg::KIND_SRA:
                    begin
                        val = {b[7], b[7:1]};
                        cy  = b[0];
                    end
                    calu_pkg::KIND_SWAP:
                    begin
                        val = {b[3:0], b[7:4]};
                        cy  = 1'b0;
                    end
                    default:
                    begin
                        val = {b[6:0], 1'b0};
                        cy  = b[7];
                    end
                endcase
                r.result = {8'h00, val};
                r.flags.z = (val == 8'h00);
                r.flags.n = 1'b0;
                r.flags.h = 1'b0;
                r.flags.c = cy;
            end
            calu_pkg::KIND_ADD_HL:
            begin
                sum17 = {1'b0, op.pair_value} + {1'b0, op.wide_addend};
                sum13 = {1'b0, op.pair_value[11:0]} + {1'b0, op.wide_addend[11:0]};
                r.result = sum17[15:0];
                r.flags.n = 1'b0;
                r.flags.h = sum13[12];
                r.flags.c = sum17[16];
            end
            default:
                r.writes_result = 1'b0;
        endcase
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic calu_pkg::op_beat_t random_op();
        calu_pkg::op_beat_t op;
        op.kind        = 5'($urandom_range(0, KIND_SPARE_HI));
        op.acc         = 8'($urandom);
        op.operand     = 8'($urandom);
        op.bit_index   = 3'($urandom);
        op.pair_value  = 16'($urandom);
        op.wide_addend = 16'($urandom);
        op.flags       = calu_pkg::flags_t'(4'($urandom));
        // equal operands reach the zero and no-borrow corners of sub and cp
        if ($urandom_range(0, 7) == 0)
            op.operand = op.acc;
        return op;
    endfunction

    function automatic calu_pkg::op_beat_t make_op(input logic [4:0] k, input logic [7:0] a,
                                                   input logic [7:0] b, input logic [15:0] hl,
                                                   input logic [15:0] wide,
                                                   input logic [3:0] fl);
        calu_pkg::op_beat_t op;
        op.kind        = k;
        op.acc         = a;
        op.operand     = b;
        op.bit_index   = 3'(k);
        op.pair_value  = hl;
        op.wide_addend = wide;
        op.flags       = calu_pkg::flags_t'(fl);
        return op;
    endfunction

    task automatic report_mismatch(input string what, input calu_pkg::op_beat_t op,
                                   input logic [15:0] got, input logic [15:0] want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("[%0t] %s: kind %0d acc %02h operand %02h idx %0d hl %04h add %04h %s%0h",
                     $time, what, op.kind, op.acc, op.operand, op.bit_index, op.pair_value,
                     op.wide_addend, $sformatf("flags %04b got %0h want ", op.flags, got),
                     want);
    endtask

    task automatic send_op(input calu_pkg::op_beat_t op);
        int unsigned gap;
        gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? idle_len() : 0);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= op.kind;
        acc         <= op.acc;
        operand     <= op.operand;
        bit_index   <= op.bit_index;
        pair_value  <= op.pair_value;
        wide_addend <= op.wide_addend;
        zero_in     <= op.flags.z;
        sub_in      <= op.flags.n;
        half_in     <= op.flags.h;
        carry_flag  <= op.flags.c;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        due_results.push_back('{op: op, want: compute_alu(op)});
    endtask

    task automatic test_each_kind();
        logic [4:0] k;
        for (int i = 0; i <= KIND_SPARE_HI; i++)
        begin
            k = 5'(i);
            send_op(make_op(k, k[0] ? 8'h00 : 8'hFF, k[1] ? 8'h00 : 8'hFF,
                            k[0] ? 16'hFFFF : 16'h0800, k[0] ? 16'h0001 : 16'h0800,
                            k[3:0]));
        end
        // nibble boundaries and borrow through the carry
        send_op(make_op(calu_pkg::KIND_ADD, 8'h0F, 8'h01, 16'h0000, 16'h0000, 4'h0));
        send_op(make_op(calu_pkg::KIND_SBC, 8'h00, 8'h00, 16'h0000, 16'h0000, 4'h1));
        send_op(make_op(calu_pkg::KIND_ADD_HL, 8'h00, 8'h00, 16'h0FFF, 16'h0001, 4'h8));
        send_op(make_op(calu_pkg::KIND_DEC, 8'h00, 8'h10, 16'h0000, 16'h0000, 4'h0));
    endtask

    task automatic test_random_ops(input int unsigned count);
        repeat (count) send_op(random_op());
    endtask

    task automatic test_back_to_back(input int unsigned count);
        steady = 1'b1;
        repeat (count) send_op(random_op());
        steady = 1'b0;
    endtask

    task automatic test_backpressure(input int unsigned count);
        steady = 1'b1;
        hold_cycles = 150;
        repeat (count) send_op(random_op());
        steady = 1'b0;
    endtask

    initial
    begin : out_ready_drive
        int unsigned low_for;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles != 0)
            begin
                low_for = hold_cycles;
                hold_cycles = 0;
                out_ready <= 1'b0;
                repeat (low_for - 1) @(posedge clk);
            end
            else if (steady || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                low_for = idle_len();
                out_ready <= 1'b0;
                repeat (low_for - 1) @(posedge clk);
            end
        end
    end

    initial
    begin : result_check
        due_t job;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (due_results.size() == 0)
                begin
                    job.op = '0;
                    report_mismatch("beat with nothing due", job.op, result, 16'h0000);
                end
                else
                begin
                    job = due_results.pop_front();
                    if (result !== job.want.result)
                        report_mismatch("result", job.op, result, job.want.result);
                    if (writes_result !== job.want.writes_result)
                        report_mismatch("writes_result", job.op, writes_result,
                                        job.want.writes_result);
                    if (zero_out !== job.want.flags.z)
                        report_mismatch("zero_out", job.op, zero_out, job.want.flags.z);
                    if (sub_out !== job.want.flags.n)
                        report_mismatch("sub_out", job.op, sub_out, job.want.flags.n);
                    if (half_out !== job.want.flags.h)
                        report_mismatch("half_out", job.op, half_out, job.want.flags.h);
                    if (carry_out !== job.want.flags.c)
                        report_mismatch("carry_out", job.op, carry_out, job.want.flags.c);
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        kind        <= calu_pkg::KIND_ADD;
        acc         <= 8'h00;
        operand     <= 8'h00;
        bit_index   <= 3'd0;
        pair_value  <= 16'h0000;
        wide_addend <= 16'h0000;
        zero_in     <= 1'b0;
        sub_in      <= 1'b0;
        half_in     <= 1'b0;
        carry_flag  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_each_kind();
        test_random_ops(400);
        test_back_to_back(200);
        test_backpressure(60);
        test_random_ops(300);

        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
